// File: src/lbnv_pkg.sv
// Shared types and constants for the letterbox NV12 to RGB converter.
`timescale 1ns / 1ps
package lbnv_pkg;
	localparam logic [1:0] CMD_WR_LUMA   = 2'd0;
	localparam logic [1:0] CMD_WR_CHROMA = 2'd1;
	localparam logic [1:0] CMD_CONVERT   = 2'd2;

	localparam logic [2:0] REG_SRC_W     = 3'd0;
	localparam logic [2:0] REG_SRC_H     = 3'd1;
	localparam logic [2:0] REG_LUMA_P    = 3'd2;
	localparam logic [2:0] REG_CHROMA_P  = 3'd3;
	localparam logic [2:0] REG_INV_SCALE = 3'd4;
	localparam logic [2:0] REG_PAD_LEFT  = 3'd5;
	localparam logic [2:0] REG_PAD_TOP   = 3'd6;
	localparam logic [2:0] REG_PAD_LEVEL = 3'd7;

	localparam int CFG_W = 20;

	localparam logic signed [15:0] K_RV = 16'sd22970;
	localparam logic signed [15:0] K_GU = 16'sd5638;
	localparam logic signed [15:0] K_GV = 16'sd11700;
	localparam logic signed [15:0] K_BU = 16'sd29032;
	localparam logic signed [26:0] ACC_MAX = 27'sd4177920;

	// Queue entry: one classified convert command.
	typedef struct packed {
		logic        pad;
		logic [8:0]  sx;
		logic [8:0]  sy;
		logic [7:0]  ux;
		logic [7:0]  uy;
	} pix_req_t;

	function automatic logic [15:0] to_q88(input logic signed [26:0] acc);
		logic signed [26:0] c;
		logic [26:0] s;
		begin
			c = acc;
			if (acc < 0) c = '0;
			if (acc > ACC_MAX) c = ACC_MAX;
			s = (27'(c) + 27'd32) >> 6;
			to_q88 = s[15:0];
		end
	endfunction
endpackage

// File: src/lbnv_front.sv
// Front end: coordinate mapping and classification of convert commands.
`timescale 1ns / 1ps
module lbnv_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [11:0]          dest_x,
	input  logic [11:0]          dest_y,
	input  logic [8:0]           source_width,
	input  logic [8:0]           source_height,
	input  logic [19:0]          inverse_scale,
	input  logic [15:0]          pad_left,
	input  logic [15:0]          pad_top,
	output logic                 req_valid,
	output lbnv_pkg::pix_req_t   req
);
	import lbnv_pkg::*;

	localparam int CB = COORD_BITS < 12 ? COORD_BITS : 12;
	localparam logic [11:0] CMASK = 12'((13'd1 << CB) - 13'd1);
	localparam int DW = 18;
	localparam int PW = DW + 20;

	logic [11:0] dx, dy;
	logic signed [DW-1:0] dfx, dfy;
	logic signed [PW-1:0] px_s1, py_s1;
	logic v_s1;
	logic [8:0] w_s1, h_s1;
	logic [PW-1:0] sxw, syw;
	logic okx, oky;
	logic [7:0] lx, ly, ux, uy;

	assign dx = dest_x & CMASK;
	assign dy = dest_y & CMASK;
	assign dfx = $signed({2'b00, dx, 4'b0000}) - $signed({2'b00, pad_left});
	assign dfy = $signed({2'b00, dy, 4'b0000}) - $signed({2'b00, pad_top});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= PW'(dfx) * $signed({1'b0, inverse_scale});
		py_s1 <= PW'(dfy) * $signed({1'b0, inverse_scale});
		w_s1 <= source_width;
		h_s1 <= source_height;
	end

	assign sxw = PW'(px_s1 >>> 20);
	assign syw = PW'(py_s1 >>> 20);
	assign okx = !px_s1[PW-1] && (sxw < PW'(w_s1));
	assign oky = !py_s1[PW-1] && (syw < PW'(h_s1));
	assign lx = (w_s1[8:1] != 8'd0) ? w_s1[8:1] - 8'd1 : 8'd0;
	assign ly = (h_s1[8:1] != 8'd0) ? h_s1[8:1] - 8'd1 : 8'd0;
	assign ux = (sxw[8:1] > lx) ? lx : sxw[8:1];
	assign uy = (syw[8:1] > ly) ? ly : syw[8:1];

	always_comb begin
		req_valid = v_s1;
		req.pad = !(okx && oky);
		req.sx  = sxw[8:0];
		req.sy  = syw[8:0];
		req.ux  = ux;
		req.uy  = uy;
	end
endmodule

// File: src/lbnv_queue.sv
// Short queue between the front end and the pixel back end.
`timescale 1ns / 1ps
module lbnv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  lbnv_pkg::pix_req_t wdata,
	output logic               rd_valid,
	output lbnv_pkg::pix_req_t rdata
);
	import lbnv_pkg::*;

	// Back end never stalls, so a two-entry ring drains one per cycle.
	pix_req_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic rd;

	assign rd_valid = cnt_q != 2'd0;
	assign rd = rd_valid;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule

// File: src/lbnv_back.sv
// Back end: frame stores, sampling and BT.601 conversion.
`timescale 1ns / 1ps
module lbnv_back #(
	parameter int LUMA_DEPTH   = 65536,
	parameter int CHROMA_DEPTH = 32768
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               lwr,
	input  logic               cwr,
	input  logic [15:0]        store_address,
	input  logic [7:0]         store_byte,
	input  logic               req_valid,
	input  lbnv_pkg::pix_req_t req,
	input  logic [8:0]         luma_row_pitch,
	input  logic [8:0]         chroma_row_pitch,
	input  logic [7:0]         pad_level,
	output logic               done,
	output logic [15:0]        red,
	output logic [15:0]        green,
	output logic [15:0]        blue,
	output logic               is_padding
);
	import lbnv_pkg::*;

	localparam int LA = $clog2(LUMA_DEPTH);
	localparam int CA = $clog2(CHROMA_DEPTH);
	localparam int CPW = CA > 17 ? CA : 17;

	logic [7:0] luma_mem [LUMA_DEPTH];
	logic [7:0] chroma_mem [CHROMA_DEPTH];

	logic lwr_s1, lwr_s2, lwr_s3, cwr_s1, cwr_s2, cwr_s3;
	logic [15:0] wa_s1, wa_s2, wa_s3;
	logic [7:0] wd_s1, wd_s2, wd_s3;
	logic v_s1, pad_s1;
	logic [17:0] la_s1;
	logic [16:0] ca_s1;
	logic v_s2, pad_s2, lok_s2, cok0_s2, cok1_s2;
	logic [7:0] y_s2, u_s2, uv_s2;
	logic [7:0] yr, ur, vr;
	logic signed [8:0] u, v;
	logic signed [26:0] ar_s3, ag_s3, ab_s3;
	logic v_s3, pad_s3;
	logic [7:0] lvl_s3;
	logic [16:0] ca1;
	logic [CPW:0] ca1x;

	assign ca1 = ca_s1 + 17'd1;
	assign ca1x = (CPW+1)'(ca1);

	// Delay store writes in registers so they land after reads of earlier pixels.
	always_ff @(posedge clk) begin
		if (lwr_s3 && ({16'd0, wa_s3} < 32'(LUMA_DEPTH)))
			luma_mem[LA'(wa_s3)] <= wd_s3;
		if (cwr_s3 && ({16'd0, wa_s3} < 32'(CHROMA_DEPTH)))
			chroma_mem[CA'(wa_s3)] <= wd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lwr_s1 <= 1'b0;
			lwr_s2 <= 1'b0;
			lwr_s3 <= 1'b0;
			cwr_s1 <= 1'b0;
			cwr_s2 <= 1'b0;
			cwr_s3 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			lwr_s1 <= lwr;
			lwr_s2 <= lwr_s1;
			lwr_s3 <= lwr_s2;
			cwr_s1 <= cwr;
			cwr_s2 <= cwr_s1;
			cwr_s3 <= cwr_s2;
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= store_address;
		wa_s2 <= wa_s1;
		wa_s3 <= wa_s2;
		wd_s1 <= store_byte;
		wd_s2 <= wd_s1;
		wd_s3 <= wd_s2;
		pad_s1 <= req.pad;
		la_s1 <= {9'd0, req.sy} * {9'd0, luma_row_pitch} + {9'd0, req.sx};
		ca_s1 <= {9'd0, req.uy} * {8'd0, chroma_row_pitch} + {8'd0, req.ux, 1'b0};
		pad_s2 <= pad_s1;
		lok_s2 <= 32'(la_s1) < 32'(LUMA_DEPTH);
		cok0_s2 <= 32'(ca_s1) < 32'(CHROMA_DEPTH);
		cok1_s2 <= 32'(ca1x) < 32'(CHROMA_DEPTH);
		y_s2 <= luma_mem[LA'(la_s1)];
		u_s2 <= chroma_mem[CA'(ca_s1)];
		uv_s2 <= chroma_mem[CA'(ca1)];
		pad_s3 <= pad_s2;
		lvl_s3 <= pad_level;
		ar_s3 <= $signed({5'b0, yr, 14'd0}) + 27'(v * K_RV);
		ag_s3 <= $signed({5'b0, yr, 14'd0}) - 27'(u * K_GU) - 27'(v * K_GV);
		ab_s3 <= $signed({5'b0, yr, 14'd0}) + 27'(u * K_BU);
		if (pad_s3) begin
			red <= {lvl_s3, 8'd0};
			green <= {lvl_s3, 8'd0};
			blue <= {lvl_s3, 8'd0};
		end else begin
			red <= to_q88(ar_s3);
			green <= to_q88(ag_s3);
			blue <= to_q88(ab_s3);
		end
		is_padding <= pad_s3;
	end

	assign yr = lok_s2 ? y_s2 : 8'd0;
	assign ur = cok0_s2 ? u_s2 : 8'd0;
	assign vr = cok1_s2 ? uv_s2 : 8'd0;
	assign u = $signed({1'b0, ur}) - 9'sd128;
	assign v = $signed({1'b0, vr}) - 9'sd128;
endmodule

// File: src/letterbox_nv12_to_rgb_planar_core.sv
// Top level of the letterbox NV12 to RGB converter.
// Usage: pulse start with cmd and its fields; busy is always low, so a
// command transfers every cycle it is offered. Commands 0 and 1 write one
// byte into the luma or chroma store after the back end's write delay
// registers, in step with the store reads of pixels accepted before them;
// they give no result. Command 2 converts one destination pixel; its
// result appears on red, green, blue and is_padding with done high for
// exactly one cycle. One pixel is accepted every clock: the
// front end (two coordinate multipliers) and the back end (address
// multiply, store read, color multiply, clip) are fully pipelined and meet
// through a two-entry queue. Registers are written with cfg_we, cfg_index
// and cfg_data; the user must write them only while no conversion is in
// flight; the block does not enforce this. Reset clears the pipeline and
// loads the register defaults; store contents are undefined until written.
// The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
module letterbox_nv12_to_rgb_planar_core #(
	parameter int LUMA_DEPTH   = 65536,
	parameter int CHROMA_DEPTH = 32768,
	parameter int COORD_BITS   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] store_address,
	input  logic [7:0]  store_byte,
	input  logic [11:0] dest_x,
	input  logic [11:0] dest_y,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [lbnv_pkg::CFG_W-1:0] cfg_data,
	output logic        done,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic        is_padding
);
	import lbnv_pkg::*;

	logic [8:0] w_q, h_q, lp_q, cp_q;
	logic [19:0] is_q;
	logic [15:0] pl_q, pt_q;
	logic [7:0] lvl_q;
	logic acc, fv, qv;
	pix_req_t freq, qreq;

	assign busy = 1'b0;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 9'd256; h_q <= 9'd256; lp_q <= 9'd256; cp_q <= 9'd256;
			is_q <= 20'd65536; pl_q <= '0; pt_q <= '0; lvl_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_W:     w_q <= cfg_data[8:0];
				REG_SRC_H:     h_q <= cfg_data[8:0];
				REG_LUMA_P:    lp_q <= cfg_data[8:0];
				REG_CHROMA_P:  cp_q <= cfg_data[8:0];
				REG_INV_SCALE: is_q <= cfg_data[19:0];
				REG_PAD_LEFT:  pl_q <= cfg_data[15:0];
				REG_PAD_TOP:   pt_q <= cfg_data[15:0];
				REG_PAD_LEVEL: lvl_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lbnv_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid(acc && cmd == CMD_CONVERT), .dest_x, .dest_y,
		.source_width(w_q), .source_height(h_q), .inverse_scale(is_q),
		.pad_left(pl_q), .pad_top(pt_q), .req_valid(fv), .req(freq)
	);

	lbnv_queue u_queue (
		.clk, .arst_n, .wr(fv), .wdata(freq), .rd_valid(qv), .rdata(qreq)
	);

	lbnv_back #(.LUMA_DEPTH(LUMA_DEPTH), .CHROMA_DEPTH(CHROMA_DEPTH)) u_back (
		.clk, .arst_n,
		.lwr(acc && cmd == CMD_WR_LUMA), .cwr(acc && cmd == CMD_WR_CHROMA),
		.store_address, .store_byte, .req_valid(qv), .req(qreq),
		.luma_row_pitch(lp_q), .chroma_row_pitch(cp_q), .pad_level(lvl_q),
		.done, .red, .green, .blue, .is_padding
	);
endmodule

// File: src/lbnv_checker.sv
// Port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps
module lbnv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  cmd,
	input logic        done,
	input logic [15:0] red,
	input logic [15:0] green,
	input logic [15:0] blue,
	input logic        is_padding
);
	import lbnv_pkg::*;

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_CONVERT |-> ##6 done) else $error("missing result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && cmd == CMD_CONVERT, 6)) else $error("extra result");
	a_pad_gray: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_padding |-> red == green && green == blue) else $error("pad not gray");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> red <= 16'd65280 && green <= 16'd65280 && blue <= 16'd65280)
		else $error("range");
endmodule

bind letterbox_nv12_to_rgb_planar_core lbnv_checker u_chk (
	.clk, .arst_n, .start, .busy, .cmd, .done, .red, .green, .blue, .is_padding
);
